/* design/c3zp_pkg.sv */
`default_nettype none

package c3zp_pkg;

    localparam int KERNEL_SIZE    = 3;
    localparam int PIXEL_W        = 8;
    localparam int WEIGHT_W       = 16;
    localparam int PROD_W         = 24;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 16;
    localparam int LINE_W         = 17;
    localparam int CFG_W          = 48;
    localparam int CFG_INDEX_W    = 3;
    localparam int FEED_DEPTH     = 4;
    localparam int RESULT_DEPTH   = 8;
    localparam int RESULT_COUNT_W = $clog2(RESULT_DEPTH + 1);

    localparam logic [CFG_W-1:0]    KERNEL_ROW_ONE_RESET = 48'h0000_0100_0000;
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET   = 16'd1024;
    localparam int                  IMAGE_WIDTH_RESET    = 1024;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_ROW_ZERO = 3'd0,
        REG_KERNEL_ROW_ONE  = 3'd1,
        REG_KERNEL_ROW_TWO  = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4
    } t_reg_index;

    typedef struct packed {
        t_op               op;
        logic [PIXEL_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_W-1:0] out_pixel;
        logic               frame_end;
    } t_out_item;

    // One column of the neighborhood, index 0 is the oldest line
    typedef logic [KERNEL_SIZE-1:0][PIXEL_W-1:0] t_column;

    // Weight [a][b] scales the neighbor at column offset a-1, line offset b-1
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][WEIGHT_W-1:0] t_kernel;

    // One step of the line store and window, as decided by the front end
    typedef struct packed {
        logic [PIXEL_W-1:0]     pixel;
        logic                   first_column;
        logic                   has_result;
        logic [KERNEL_SIZE-1:0] x_pad;
        logic [KERNEL_SIZE-1:0] y_pad;
        logic                   frame_end;
    } t_feed_op;

endpackage

`default_nettype wire

/* design/conv3x3_zero_pad_top.sv */
`default_nettype none

// 3x3 correlation of an 8-bit raster image with zero padding at the borders.
// Input channel (push/full): pixel items in raster order, column fastest, then
// flush items once the whole image is in; each flush drains one result.
// Result channel (empty/pop): out_pixel and frame_end, oldest first.
// Config port: write kernel rows and geometry only while the block is idle;
// a geometry write restarts the image.
// Throughput: one item per cycle while full is low. A flush that must step over
// the first drain position needs a second step, and full is high while that
// step is pending; the one-read, one-write line store and the single back
// pipeline set this. A result is completed by the item that arrives
// image_width+1 items after its center pixel, then passes the step queue and
// the back end's steps before it reaches the result ports.
// Reset clears all positions and the window, loads the identity kernel and a
// 1024x1024 geometry. The line store is not cleared and needs no pass.
// When the receiver stalls, results collect in an 8-entry result queue, the
// back end stops taking steps, the 4-entry step queue fills and full rises.

module conv3x3_zero_pad_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  c3zp_pkg::t_in_item                   i_item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output c3zp_pkg::t_out_item                  o_result,
    input  logic                                 i_cfg_we,
    input  logic [c3zp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [c3zp_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int ColW    = $clog2(MAX_WIDTH);
    localparam int WidthW  = c3zp_pkg::WIDTH_W;
    localparam int HeightW = c3zp_pkg::HEIGHT_W;
    localparam int OpW     = $bits(c3zp_pkg::t_feed_op);
    localparam int FeedW   = ColW + OpW;
    localparam int ResW    = $bits(c3zp_pkg::t_out_item);
    localparam logic [WidthW-1:0] WidthReset =
        WidthW'((MAX_WIDTH < c3zp_pkg::IMAGE_WIDTH_RESET) ? MAX_WIDTH
                                                          : c3zp_pkg::IMAGE_WIDTH_RESET);

    // Configuration registers
    c3zp_pkg::t_kernel    r_kernel;
    logic [WidthW-1:0]    r_width;
    logic [HeightW-1:0]   r_height;
    logic [WidthW-1:0]    width_cfg;
    logic [HeightW-1:0]   height_cfg;
    logic                 cfg_restart;

    // Front to back
    logic                 feed_push;
    c3zp_pkg::t_feed_op   front_op;
    logic [ColW-1:0]      front_col;
    logic                 feed_full;
    logic                 feed_empty;
    logic [FeedW-1:0]     feed_rdata;
    logic                 back_take;

    // Back to result queue
    logic                                res_push;
    c3zp_pkg::t_out_item                 res_item;
    logic [ResW-1:0]                     res_head;
    logic [c3zp_pkg::RESULT_COUNT_W-1:0] res_count;

    // Clamp geometry: zero counts as one, width saturates at the line store size
    always_comb begin
        width_cfg  = i_cfg_data[WidthW-1:0];
        height_cfg = i_cfg_data[HeightW-1:0];
        if (width_cfg == '0) begin
            width_cfg = WidthW'(1);
        end else if (32'(width_cfg) > MAX_WIDTH) begin
            width_cfg = WidthW'(MAX_WIDTH);
        end
        if (height_cfg == '0) begin
            height_cfg = HeightW'(1);
        end
        cfg_restart = i_cfg_we
                      && ((c3zp_pkg::t_reg_index'(i_cfg_index) == c3zp_pkg::REG_IMAGE_WIDTH)
                          || (c3zp_pkg::t_reg_index'(i_cfg_index)
                              == c3zp_pkg::REG_IMAGE_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel[0] <= '0;
            r_kernel[1] <= c3zp_pkg::KERNEL_ROW_ONE_RESET;
            r_kernel[2] <= '0;
            r_width     <= WidthReset;
            r_height    <= c3zp_pkg::IMAGE_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (c3zp_pkg::t_reg_index'(i_cfg_index))
                c3zp_pkg::REG_KERNEL_ROW_ZERO: begin
                    r_kernel[0] <= i_cfg_data;
                end
                c3zp_pkg::REG_KERNEL_ROW_ONE: begin
                    r_kernel[1] <= i_cfg_data;
                end
                c3zp_pkg::REG_KERNEL_ROW_TWO: begin
                    r_kernel[2] <= i_cfg_data;
                end
                c3zp_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= width_cfg;
                end
                c3zp_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= height_cfg;
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Front end: accept items, track positions, decide padding and results
    c3zp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_restart (cfg_restart),
        .i_q_full  (feed_full),
        .o_q_push  (feed_push),
        .o_op      (front_op),
        .o_col     (front_col)
    );

    // Step queue between the two halves
    c3zp_fifo #(
        .WIDTH (FeedW),
        .DEPTH (c3zp_pkg::FEED_DEPTH)
    ) u_feed_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (feed_push),
        .i_data  ({front_col, front_op}),
        .i_pop   (back_take),
        .o_data  (feed_rdata),
        .o_full  (feed_full),
        .o_empty (feed_empty),
        .o_count ()
    );

    // Back end: line store, window, multiply and sum
    c3zp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!feed_empty),
        .i_op        (c3zp_pkg::t_feed_op'(feed_rdata[OpW-1:0])),
        .i_col       (feed_rdata[FeedW-1 -: ColW]),
        .o_take      (back_take),
        .i_kernel    (r_kernel),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res_item  (res_item)
    );

    // Result queue toward the receiver
    c3zp_fifo #(
        .WIDTH (ResW),
        .DEPTH (c3zp_pkg::RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_full  (),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_result = c3zp_pkg::t_out_item'(res_head);

endmodule

`default_nettype wire

/* design/c3zp_ram.sv */
`default_nettype none

module c3zp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/c3zp_fifo.sv */
`default_nettype none

module c3zp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PtrW   = $clog2(DEPTH);
    localparam int CountW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PtrW-1:0]   r_wptr, n_wptr;
    logic [PtrW-1:0]   r_rptr, n_rptr;
    logic [CountW-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == CountW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CountW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/c3zp_front.sv */
`default_nettype none

module c3zp_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  c3zp_pkg::t_in_item                i_item,
    output logic                              o_full,
    input  logic [c3zp_pkg::WIDTH_W-1:0]      i_width,
    input  logic [c3zp_pkg::HEIGHT_W-1:0]     i_height,
    input  logic                              i_restart,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output c3zp_pkg::t_feed_op                o_op,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col
);

    localparam int ColW    = $clog2(MAX_WIDTH);
    localparam int WidthW  = c3zp_pkg::WIDTH_W;
    localparam int HeightW = c3zp_pkg::HEIGHT_W;
    localparam int LineW   = c3zp_pkg::LINE_W;
    localparam int CmpW    = ((ColW > WidthW) ? ColW : WidthW) + 1;

    logic [ColW-1:0]    r_in_col, n_in_col;
    logic [LineW-1:0]   r_in_line, n_in_line;
    logic [ColW-1:0]    r_out_col, n_out_col;
    logic [HeightW-1:0] r_out_line, n_out_line;
    logic               r_extra, n_extra;

    logic [CmpW-1:0]    width_x;
    logic [CmpW-1:0]    in_col_inc;
    logic [CmpW-1:0]    out_col_inc;
    logic [LineW-1:0]   height_x;
    logic [LineW-1:0]   out_line_inc;
    logic               complete;
    logic               accept;
    logic               flush_item;
    logic               feed;
    logic               ready;
    logic               in_wrap;
    logic               out_col_last;
    logic               out_line_last;

    // A second step is pending while a flush had to step over the drain start
    assign o_full = i_q_full || r_extra;

    always_comb begin
        width_x       = CmpW'(i_width);
        height_x      = LineW'(i_height);
        in_col_inc    = CmpW'(r_in_col) + CmpW'(1);
        out_col_inc   = CmpW'(r_out_col) + CmpW'(1);
        out_line_inc  = LineW'(r_out_line) + LineW'(1);
        complete      = r_in_line >= height_x;
        accept        = i_push && !o_full;
        flush_item    = i_item.op == c3zp_pkg::OP_FLUSH;
        in_wrap       = in_col_inc >= width_x;
        out_col_last  = out_col_inc >= width_x;
        out_line_last = out_line_inc >= height_x;
        ready         = (r_in_line >= LineW'(2))
                        || ((r_in_line == LineW'(1)) && (r_in_col != '0));

        o_op = '0;
        if (r_extra) begin
            feed           = !i_q_full;
            o_op.pixel     = '0;
        end else begin
            feed           = accept && (flush_item ? complete : !complete);
            o_op.pixel     = flush_item ? '0 : i_item.pixel;
        end
        o_op.first_column = r_in_col == '0;
        o_op.has_result   = ready;
        o_op.x_pad[0]     = r_out_col == '0;
        o_op.x_pad[1]     = CmpW'(r_out_col) >= width_x;
        o_op.x_pad[2]     = out_col_last;
        o_op.y_pad[0]     = r_out_line == '0;
        o_op.y_pad[1]     = LineW'(r_out_line) >= height_x;
        o_op.y_pad[2]     = out_line_last;
        o_op.frame_end    = out_col_last && out_line_last;
        o_q_push          = feed;
        o_col             = r_in_col;

        n_in_col   = r_in_col;
        n_in_line  = r_in_line;
        n_out_col  = r_out_col;
        n_out_line = r_out_line;
        if (feed) begin
            // advance the input position
            if (in_wrap) begin
                n_in_col  = '0;
                n_in_line = r_in_line + LineW'(1);
            end else begin
                n_in_col  = ColW'(in_col_inc);
            end
            // advance the output position; the last output restarts the frame
            if (ready) begin
                if (out_col_last && out_line_last) begin
                    n_in_col   = '0;
                    n_in_line  = '0;
                    n_out_col  = '0;
                    n_out_line = '0;
                end else if (out_col_last) begin
                    n_out_col  = '0;
                    n_out_line = r_out_line + HeightW'(1);
                end else begin
                    n_out_col  = ColW'(out_col_inc);
                end
            end
        end

        if (r_extra) begin
            n_extra = i_q_full;
        end else begin
            n_extra = feed && flush_item && !ready;
        end

        if (i_restart) begin
            n_in_col   = '0;
            n_in_line  = '0;
            n_out_col  = '0;
            n_out_line = '0;
            n_extra    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_line  <= '0;
            r_out_col  <= '0;
            r_out_line <= '0;
            r_extra    <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_line  <= n_in_line;
            r_out_col  <= n_out_col;
            r_out_line <= n_out_line;
            r_extra    <= n_extra;
        end
    end

endmodule

`default_nettype wire

/* design/c3zp_back.sv */
`default_nettype none

module c3zp_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  c3zp_pkg::t_feed_op                    i_op,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_col,
    output logic                                  o_take,
    input  c3zp_pkg::t_kernel                     i_kernel,
    input  logic [c3zp_pkg::RESULT_COUNT_W-1:0]   i_res_count,
    output logic                                  o_res_push,
    output c3zp_pkg::t_out_item                   o_res_item
);

    localparam int ColW    = $clog2(MAX_WIDTH);
    localparam int Ks      = c3zp_pkg::KERNEL_SIZE;
    localparam int PixW    = c3zp_pkg::PIXEL_W;
    localparam int ProdW   = c3zp_pkg::PROD_W;
    localparam int MultW   = c3zp_pkg::WEIGHT_W + PixW + 1;
    localparam int CreditW = c3zp_pkg::RESULT_COUNT_W + 1;

    // step 1: line store read data is back
    logic                  r_b1_valid;
    c3zp_pkg::t_feed_op    r_b1_op;
    logic [ColW-1:0]       r_b1_col;
    logic                  r_fwd_hit;
    logic [2*PixW-1:0]     r_fwd_word;
    c3zp_pkg::t_column     r_win [Ks];

    // step 2: masked neighborhood, step 3: products
    logic                  r_b2_valid;
    logic                  r_b2_fe;
    logic [PixW-1:0]       r_b2_pix [Ks][Ks];
    logic                  r_b3_valid;
    logic                  r_b3_fe;
    logic signed [ProdW-1:0] r_b3_prod [Ks][Ks];

    logic [2*PixW-1:0]     ram_rdata;
    logic [2*PixW-1:0]     word;
    logic [PixW-1:0]       top;
    logic [PixW-1:0]       mid;
    c3zp_pkg::t_column     new_col;
    c3zp_pkg::t_column     shifted [Ks];
    c3zp_pkg::t_column     cols [Ks];
    logic [PixW-1:0]       n_pix [Ks][Ks];
    logic signed [MultW-1:0] mult [Ks][Ks];
    logic [ProdW-1:0]      adj;
    logic [PixW-1:0]       sum;
    logic [CreditW-1:0]    in_flight;

    // Hold feeds back unless the result queue has room for all in flight
    always_comb begin
        in_flight = CreditW'(r_b1_valid) + CreditW'(r_b2_valid) + CreditW'(r_b3_valid);
        o_take    = i_valid
                    && ((CreditW'(i_res_count) + in_flight) < CreditW'(c3zp_pkg::RESULT_DEPTH));
    end

    c3zp_ram #(
        .WIDTH (2 * PixW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_b1_valid),
        .i_waddr (r_b1_col),
        .i_wdata ({mid, r_b1_op.pixel}),
        .i_raddr (i_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        word       = r_fwd_hit ? r_fwd_word : ram_rdata;
        top        = word[2*PixW-1:PixW];
        mid        = word[PixW-1:0];
        new_col[0] = top;
        new_col[1] = mid;
        new_col[2] = r_b1_op.pixel;
        shifted[0] = r_win[1];
        shifted[1] = r_win[2];
        shifted[2] = new_col;
        if (r_b1_op.first_column) begin
            // output sits at the last column of the line before
            cols[0] = r_win[1];
            cols[1] = r_win[2];
            cols[2] = '0;
        end else begin
            cols    = shifted;
        end
        for (int a = 0; a < Ks; a++) begin
            for (int b = 0; b < Ks; b++) begin
                n_pix[a][b] = (r_b1_op.x_pad[a] || r_b1_op.y_pad[b]) ? '0 : cols[a][b];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < Ks; a++) begin
            for (int b = 0; b < Ks; b++) begin
                mult[a][b] = $signed(i_kernel[a][b]) * $signed({1'b0, r_b2_pix[a][b]});
            end
        end
    end

    // Truncate each product toward zero, keep its low byte, wrap the sum
    always_comb begin
        sum = '0;
        adj = '0;
        for (int a = 0; a < Ks; a++) begin
            for (int b = 0; b < Ks; b++) begin
                adj = r_b3_prod[a][b] + (r_b3_prod[a][b][ProdW-1] ? ProdW'(255) : ProdW'(0));
                sum = sum + adj[2*PixW-1:PixW];
            end
        end
        o_res_push           = r_b3_valid;
        o_res_item.out_pixel = sum;
        o_res_item.frame_end = r_b3_fe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            for (int a = 0; a < Ks; a++) begin
                r_win[a] <= '0;
            end
        end else begin
            r_b1_valid <= o_take;
            r_b2_valid <= r_b1_valid && r_b1_op.has_result;
            r_b3_valid <= r_b2_valid;
            r_fwd_hit  <= o_take && r_b1_valid && (i_col == r_b1_col);
            if (r_b1_valid) begin
                for (int a = 0; a < Ks; a++) begin
                    r_win[a] <= (r_b1_op.has_result && r_b1_op.frame_end) ? '0 : shifted[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_op    <= i_op;
        r_b1_col   <= i_col;
        r_fwd_word <= {mid, r_b1_op.pixel};
        r_b2_fe    <= r_b1_op.frame_end;
        r_b2_pix   <= n_pix;
        r_b3_fe    <= r_b2_fe;
        for (int a = 0; a < Ks; a++) begin
            for (int b = 0; b < Ks; b++) begin
                r_b3_prod[a][b] <= ProdW'(mult[a][b]);
            end
        end
    end

endmodule

`default_nettype wire

/* design/c3zp_checker.sv */
`default_nettype none

module c3zp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input c3zp_pkg::t_out_item o_result
);

    // Items taken but not yet matched by a result; sticky once it saturates
    logic [31:0] r_owed;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
            r_sat  <= 1'b0;
        end else begin
            if (r_owed == '1) begin
                r_sat <= 1'b1;
            end
            r_owed <= r_owed + 32'(push && !full) - 32'(pop && !empty);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("block not idle after reset");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |-> ((r_owed != '0) || r_sat))
        else $error("more results than items taken");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind conv3x3_zero_pad_top c3zp_checker u_c3zp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_W          = 1024;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int REPORT_LIMIT   = 10;
    localparam int ITEMS_PER_MODE = 80;
    localparam int GAP_HEAVY      = 51;
    localparam int GAP_LIGHT      = 18;

    // Register indexes past the last mapped register; writes there must be dropped
    localparam logic [c3zp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [c3zp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // Three columns of the neighborhood, column 0 on the left
    typedef c3zp_pkg::t_column [c3zp_pkg::KERNEL_SIZE-1:0] t_nbhd;

    typedef logic [c3zp_pkg::WIDTH_W-1:0]  t_width;
    typedef logic [c3zp_pkg::HEIGHT_W-1:0] t_height;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             push        = 1'b0;
    c3zp_pkg::t_in_item               i_item      = '0;
    logic                             full;
    logic                             empty;
    logic                             pop         = 1'b0;
    c3zp_pkg::t_out_item              o_result;
    logic                             i_cfg_we    = 1'b0;
    logic [c3zp_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [c3zp_pkg::CFG_W-1:0]       i_cfg_data  = '0;

    conv3x3_zero_pad_top #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Local copy of the block's state, kept in step with accepted items
    // ------------------------------------------------------------------
    logic [c3zp_pkg::CFG_W-1:0]   krow [c3zp_pkg::KERNEL_SIZE] =
        '{'0, c3zp_pkg::KERNEL_ROW_ONE_RESET, '0};
    int                           img_w = c3zp_pkg::IMAGE_WIDTH_RESET;
    int                           img_h = int'(c3zp_pkg::IMAGE_HEIGHT_RESET);
    // Lower half holds the newest line, upper half the line before it
    logic [c3zp_pkg::PIXEL_W-1:0] lstore [2*MAX_W] = '{default: '0};
    t_nbhd                        win = '0;
    int                           in_col = 0;
    int                           in_ln  = 0;
    int                           out_col = 0;
    int                           out_ln  = 0;

    c3zp_pkg::t_in_item   pixel_stream [$];     // items waiting to be pushed
    c3zp_pkg::t_out_item  awaited_pixels [$];   // predicted outputs, oldest first
    t_idle_mode idle_mode = IDLE_NONE;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    function automatic void rewind_frame();
        in_col  = 0;
        in_ln   = 0;
        out_col = 0;
        out_ln  = 0;
    endfunction

    // Signed Q8.8 weight times pixel, truncated toward zero, low byte kept
    function automatic logic [c3zp_pkg::PIXEL_W-1:0] weighted_pixel(
            logic [c3zp_pkg::WEIGHT_W-1:0] weight, logic [c3zp_pkg::PIXEL_W-1:0] p);
        int prod;
        int mag;
        prod = int'($signed(weight)) * int'(p);
        mag  = (prod < 0) ? -prod : prod;
        mag  = mag >> 8;
        return (prod < 0) ? 8'(-mag) : 8'(mag);
    endfunction

    // Wrapped sum over the neighborhood of the current output position;
    // anything outside the image reads as zero
    function automatic logic [c3zp_pkg::PIXEL_W-1:0] window_sum(t_nbhd nb);
        logic [c3zp_pkg::PIXEL_W-1:0] acc;
        logic [c3zp_pkg::PIXEL_W-1:0] p;
        int x;
        int y;
        acc = '0;
        for (int a = 0; a < c3zp_pkg::KERNEL_SIZE; a++) begin
            x = out_col + a - 1;
            for (int b = 0; b < c3zp_pkg::KERNEL_SIZE; b++) begin
                y = out_ln + b - 1;
                p = nb[a][b];
                if (x < 0 || x >= img_w || y < 0 || y >= img_h)
                    p = '0;
                acc += weighted_pixel(krow[a][c3zp_pkg::WEIGHT_W*b +: c3zp_pkg::WEIGHT_W], p);
            end
        end
        return acc;
    endfunction

    // Shift one pixel through the line store and window; return 1 when it
    // completes an output position
    function automatic bit advance_window(input logic [c3zp_pkg::PIXEL_W-1:0] v,
                                          output c3zp_pkg::t_out_item res);
        int c;
        int l;
        int idx;
        logic [c3zp_pkg::PIXEL_W-1:0] top;
        logic [c3zp_pkg::PIXEL_W-1:0] mid;
        t_nbhd nb;
        bit ready;
        c     = in_col;
        l     = in_ln;
        idx   = (c < MAX_W) ? c : MAX_W - 1;
        top   = lstore[MAX_W + idx];
        mid   = lstore[idx];
        ready = (l >= 2) || (l == 1 && c >= 1);
        res   = '0;
        nb    = '0;

        lstore[MAX_W + idx] = mid;
        lstore[idx]         = v;

        // First column: the output belongs to the last column of an older
        // line, so its right neighbor column is padding
        if (c == 0) begin
            nb[0] = win[1];
            nb[1] = win[2];
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = {v, mid, top};
        if (c != 0)
            nb = win;

        if (c + 1 >= img_w) begin
            in_col = 0;
            in_ln++;
        end else begin
            in_col = c + 1;
        end

        if (!ready)
            return 1'b0;

        res.out_pixel = window_sum(nb);
        res.frame_end = (out_col + 1 >= img_w) && (out_ln + 1 >= img_h);
        if (res.frame_end) begin
            rewind_frame();
            win = '0;
        end else if (out_col + 1 >= img_w) begin
            out_col = 0;
            out_ln++;
        end else begin
            out_col++;
        end
        return 1'b1;
    endfunction

    // Work out what one accepted item produces and queue it
    function automatic void convolve_item(c3zp_pkg::t_in_item it);
        c3zp_pkg::t_out_item r;
        bit                  complete;
        complete = in_ln >= img_h;
        if (it.op == c3zp_pkg::OP_PIXEL) begin
            // pixels past a complete image are dropped
            if (!complete && advance_window(it.pixel, r))
                awaited_pixels.push_back(r);
        end else if (complete) begin
            // a flush steps over at most one position that has no output
            if (advance_window('0, r))
                awaited_pixels.push_back(r);
            else if (advance_window('0, r))
                awaited_pixels.push_back(r);
        end
    endfunction

    function automatic bit sender_rests();
        return (idle_mode == IDLE_SENDER && $urandom_range(99) < GAP_HEAVY) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < GAP_LIGHT);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < GAP_HEAVY) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < GAP_LIGHT);
    endfunction

    task automatic note_mismatch(string what, c3zp_pkg::t_out_item want,
                                 c3zp_pkg::t_out_item got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected pixel %0d frame_end %0b, got pixel %0d frame_end %0b",
                     $time, what, want.out_pixel, want.frame_end,
                     got.out_pixel, got.frame_end);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** conv3x3_zero_pad_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: predict each accepted item, then load the next one or idle.
    // Hold the current item while full is high.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                convolve_item(i_item);
            if (!push || !full) begin
                if (pixel_stream.size() != 0 && !sender_rests()) begin
                    push   <= 1'b1;
                    i_item <= pixel_stream.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction,
    // field by field; stall pop at random in the receiver modes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        c3zp_pkg::t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (awaited_pixels.size() == 0) begin
                    note_mismatch("result with nothing predicted", '0, o_result);
                end else begin
                    want = awaited_pixels.pop_front();
                    if (o_result.out_pixel !== want.out_pixel)
                        note_mismatch("out_pixel mismatch", want, o_result);
                    if (o_result.frame_end !== want.frame_end)
                        note_mismatch("frame_end mismatch", want, o_result);
                end
            end
            pop <= !receiver_stalls();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Wait until every item is in and every prediction has come out, then
    // give items that produce nothing time to leave the pipeline
    task automatic settle();
        do @(negedge i_clk);
        while (pixel_stream.size() != 0 || push || awaited_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the local copy; only call when idle
    task automatic cfg_write(logic [c3zp_pkg::CFG_INDEX_W-1:0] index,
                             logic [c3zp_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            c3zp_pkg::REG_KERNEL_ROW_ZERO: krow[0] = data;
            c3zp_pkg::REG_KERNEL_ROW_ONE:  krow[1] = data;
            c3zp_pkg::REG_KERNEL_ROW_TWO:  krow[2] = data;
            c3zp_pkg::REG_IMAGE_WIDTH: begin
                // zero counts as one, oversize saturates
                if (data[c3zp_pkg::WIDTH_W-1:0] == '0)
                    img_w = 1;
                else if (data[c3zp_pkg::WIDTH_W-1:0] > MAX_W)
                    img_w = MAX_W;
                else
                    img_w = int'(data[c3zp_pkg::WIDTH_W-1:0]);
                rewind_frame();
            end
            c3zp_pkg::REG_IMAGE_HEIGHT: begin
                img_h = (data[c3zp_pkg::HEIGHT_W-1:0] == '0) ? 1
                                                             : int'(data[c3zp_pkg::HEIGHT_W-1:0]);
                rewind_frame();
            end
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [c3zp_pkg::CFG_W-1:0] random_word();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Geometry with junk in the bits above the register width
    task automatic set_width(t_width w);
        logic [c3zp_pkg::CFG_W-1:0] data;
        data = random_word();
        data[c3zp_pkg::WIDTH_W-1:0] = w;
        cfg_write(c3zp_pkg::REG_IMAGE_WIDTH, data);
    endtask

    task automatic set_height(t_height h);
        logic [c3zp_pkg::CFG_W-1:0] data;
        data = random_word();
        data[c3zp_pkg::HEIGHT_W-1:0] = h;
        cfg_write(c3zp_pkg::REG_IMAGE_HEIGHT, data);
    endtask

    function automatic logic [c3zp_pkg::WEIGHT_W-1:0] random_weight();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(1024)) - 16'd512;
            2: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    default: return 16'h0100;
                endcase
            end
            default: return 16'($urandom_range(4096)) - 16'd2048;
        endcase
    endfunction

    function automatic logic [c3zp_pkg::CFG_W-1:0] random_row();
        return {random_weight(), random_weight(), random_weight()};
    endfunction

    function automatic logic [c3zp_pkg::PIXEL_W-1:0] random_pixel();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic void queue_pixel(logic [c3zp_pkg::PIXEL_W-1:0] v);
        pixel_stream.push_back('{op: c3zp_pkg::OP_PIXEL, pixel: v});
    endfunction

    // Flush items carry junk in the pixel field
    function automatic void queue_flush();
        pixel_stream.push_back('{op: c3zp_pkg::OP_FLUSH, pixel: 8'($urandom)});
    endfunction

    // One whole image plus the flushes that drain it. With noise, add a
    // flush before the image is complete, a pixel after it is complete and
    // a flush after the frame end; the block drops all three.
    task automatic queue_image(int w, int h, bit noisy, output int count);
        int n;
        int flushes;
        n       = w * h;
        flushes = (n < w + 1) ? n : w + 1;
        for (int i = 0; i < n; i++) begin
            if (noisy && i == n - 1)
                queue_flush();
            queue_pixel(random_pixel());
        end
        if (noisy)
            queue_pixel(random_pixel());
        repeat (flushes) queue_flush();
        if (noisy)
            queue_flush();
        count = n + flushes;
    endtask

    // Small random images, back to back under one geometry now and then,
    // sometimes cut short and restarted by the next geometry write
    task automatic random_images(int quota);
        int sent;
        int w;
        int h;
        int cut;
        int count;
        sent = 0;
        while (sent < quota) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if ($urandom_range(1))
                cfg_write(c3zp_pkg::REG_KERNEL_ROW_ZERO, random_row());
            if ($urandom_range(1))
                cfg_write(c3zp_pkg::REG_KERNEL_ROW_ONE, random_row());
            if ($urandom_range(1))
                cfg_write(c3zp_pkg::REG_KERNEL_ROW_TWO, random_row());
            set_width(t_width'(w));
            set_height(t_height'(h));
            cfg_close();
            if (w * h > 1 && $urandom_range(9) == 0) begin
                cut = $urandom_range(1, w * h - 1);
                repeat (cut) queue_pixel(random_pixel());
                sent += cut;
            end else begin
                repeat ($urandom_range(1, 2)) begin
                    queue_image(w, h, $urandom_range(3) == 0, count);
                    sent += count;
                end
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int count;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: a few pixels give no output yet, and a flush that
        // the block must drop because the image is not complete
        repeat (8) queue_pixel(random_pixel());
        queue_flush();
        settle();

        // Identity kernel from reset on a small image; the geometry write
        // also restarts the image cut short above
        set_width(t_width'(4));
        set_height(t_height'(3));
        cfg_close();
        queue_image(4, 3, 1'b1, count);
        settle();

        // Kernel extremes on a 3x3 image. Pause in the middle until all
        // outputs are out.
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_ZERO, {16'hFFFF, 16'h7FFF, 16'h8000});
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_ONE,  {16'h7FFF, 16'h8000, 16'h0100});
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_TWO,  {16'h0000, 16'h0080, 16'hFF00});
        set_width(t_width'(3));
        set_height(t_height'(3));
        cfg_close();
        queue_flush();
        for (int i = 0; i < 9; i++)
            queue_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
        settle();
        queue_pixel(random_pixel());
        repeat (4) queue_flush();
        queue_flush();
        settle();

        // Unmapped indexes, zero geometry read as 1x1: one flush has to step
        // over a position with no output before it can drain the pixel
        cfg_write(REG_UNMAPPED_LO, '1);
        cfg_write(REG_UNMAPPED_HI, '1);
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_TWO, '1);
        set_width(t_width'(0));
        set_height(t_height'(0));
        cfg_close();
        queue_pixel(8'hFF);
        queue_flush();
        settle();

        // Oversize width saturates to the full line, single line; a short
        // run gives no output yet
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_ZERO, random_row());
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_ONE, random_row());
        cfg_write(c3zp_pkg::REG_KERNEL_ROW_TWO, random_row());
        set_width('1);
        set_height(t_height'(1));
        cfg_close();
        repeat (5) queue_pixel(random_pixel());
        settle();

        // Two pixels wide, one line
        set_width(t_width'(2));
        cfg_close();
        queue_image(2, 1, 1'b1, count);
        settle();

        // One pixel wide, tallest image, cut short after a few outputs
        set_width(t_width'(1));
        set_height('1);
        cfg_close();
        repeat (6) queue_pixel(random_pixel());
        settle();

        // Random part, once per idling mode
        idle_mode = IDLE_NONE;
        random_images(ITEMS_PER_MODE);
        idle_mode = IDLE_SENDER;
        random_images(ITEMS_PER_MODE);
        idle_mode = IDLE_RECEIVER;
        random_images(ITEMS_PER_MODE);
        idle_mode = IDLE_BOTH;
        random_images(ITEMS_PER_MODE);

        settle();
        if (mismatch_count == 0)
            $display("** conv3x3_zero_pad_top: PASSED **");
        else
            $display("** conv3x3_zero_pad_top: FAILED **");
        $finish;
    end

endmodule
